[rtl/kwsc_pkg.sv]
// ----------------------------------------------------------------------------
// Keyword substitution cipher package
// Shared widths, alphabet constants, register indexes and types.
// ----------------------------------------------------------------------------
package kwsc_pkg;

   // Number of key letters that build the cipher alphabet.
   localparam int KEY_LENGTH = 5;

   localparam int LETTER_COUNT  = 26;
   localparam int LETTER_WIDTH  = 5;
   localparam int RANK_WIDTH    = $clog2(KEY_LENGTH + 1);
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_DAT_WIDTH = 5;

   typedef logic [LETTER_WIDTH-1:0] letter_type;
   typedef letter_type [KEY_LENGTH-1:0] key_set_type;

   // Alphabet index of the space symbol and of the last letter.
   localparam letter_type SPACE_INDEX = letter_type'(LETTER_COUNT);
   localparam letter_type LAST_LETTER = letter_type'(LETTER_COUNT - 1);

   // Register indexes: key letters occupy 0 to KEY_LENGTH-1.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KEY_FIRST = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIRECTION = 3'd5;

   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
   localparam logic [7:0] ASCII_SPACE   = 8'h20;
   localparam logic [7:0] ASCII_CASE    = 8'h20;

endpackage

[rtl/kwsc_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one message byte per beat.
// ----------------------------------------------------------------------------
interface kwsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_message;

   modport source (output valid, output char_in, output end_of_message, input ready);
   modport sink   (input valid, input char_in, input end_of_message, output ready);
endinterface

[rtl/kwsc_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one substituted byte per beat.
// ----------------------------------------------------------------------------
interface kwsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       invalid;
   logic       end_flag;

   modport source (output valid, output char_out, output invalid, output end_flag,
                   input ready);
   modport sink   (input valid, input char_out, input invalid, input end_flag,
                   output ready);
endinterface

[rtl/kwsc_csr_if.sv]
// ----------------------------------------------------------------------------
// Register write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface kwsc_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [4:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/kwsc_tables.sv]
// ----------------------------------------------------------------------------
// Cipher table builder
// Sweeps the 26 letters after reset and after every key write and fills the
// forward and inverse substitution tables; offers a combinational lookup.
// ----------------------------------------------------------------------------
module kwsc_tables (
   input  logic                clock,
   input  logic                reset,
   input  logic                rebuild,
   input  kwsc_pkg::key_set_type key_letters,
   input  kwsc_pkg::letter_type  lookup_index,
   input  logic                lookup_decrypt,
   output kwsc_pkg::letter_type  lookup_result,
   output logic                busy
);
   import kwsc_pkg::*;

   letter_type forward_ff [LETTER_COUNT];
   letter_type inverse_ff [LETTER_COUNT];

   logic       busy_ff,   busy_in;
   letter_type letter_ff, letter_in;
   letter_type skip_ff,   skip_in;

   logic [KEY_LENGTH-1:0] first_seen;
   logic [RANK_WIDTH-1:0] rank [KEY_LENGTH];
   logic [RANK_WIDTH-1:0] distinct;
   logic                  hit;
   logic [RANK_WIDTH-1:0] hit_rank;
   letter_type            position;

   // A key position counts when its letter is valid and not seen earlier;
   // its rank is the number of counted positions before it.
   always_comb begin
      logic dup;
      logic [RANK_WIDTH-1:0] count;
      count = '0;
      for (int j = 0; j < KEY_LENGTH; j++) begin
         dup = 1'b0;
         for (int i = 0; i < KEY_LENGTH; i++) begin
            if (i < j && key_letters[i] == key_letters[j]) begin
               dup = 1'b1;
            end
         end
         first_seen[j] = (key_letters[j] <= LAST_LETTER) && !dup;
         rank[j]       = count;
         if (first_seen[j]) begin
            count = count + 1'b1;
         end
      end
      distinct = count;
   end

   // Cipher position of the current letter: its key rank, or after all key
   // letters in order among the letters not in the key.
   always_comb begin
      hit      = 1'b0;
      hit_rank = '0;
      for (int j = 0; j < KEY_LENGTH; j++) begin
         if (first_seen[j] && key_letters[j] == letter_ff) begin
            hit      = 1'b1;
            hit_rank = rank[j];
         end
      end
      position = hit ? LETTER_WIDTH'(hit_rank) : LETTER_WIDTH'(distinct) + skip_ff;
   end

   always_comb begin
      busy_in   = busy_ff;
      letter_in = letter_ff;
      skip_in   = skip_ff;
      if (rebuild) begin
         busy_in   = 1'b1;
         letter_in = '0;
         skip_in   = '0;
      end else if (busy_ff) begin
         letter_in = letter_ff + 1'b1;
         skip_in   = skip_ff + LETTER_WIDTH'(!hit);
         if (letter_ff == LAST_LETTER) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         letter_ff <= '0;
         skip_ff   <= '0;
      end else begin
         busy_ff   <= busy_in;
         letter_ff <= letter_in;
         skip_ff   <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !rebuild) begin
         forward_ff[position]  <= letter_ff;
         inverse_ff[letter_ff] <= position;
      end
   end

   always_comb begin
      if (lookup_index == SPACE_INDEX) begin
         lookup_result = SPACE_INDEX;
      end else if (lookup_decrypt == DIR_DECRYPT) begin
         lookup_result = inverse_ff[lookup_index];
      end else begin
         lookup_result = forward_ff[lookup_index];
      end
   end

   assign busy = busy_ff;

endmodule

[rtl/keyword_substitution_cipher.sv]
// ----------------------------------------------------------------------------
// Keyword substitution cipher
// Streams message bytes through a keyed substitution over a to z and space.
// ----------------------------------------------------------------------------
// The block has three valid/ready channels. The request channel (req_bus)
// carries one message byte and its end-of-message mark per beat. The response
// channel (rsp_bus) returns one beat per request beat, in order: the
// substituted lower-case letter or space, an invalid flag for bytes that are
// neither letter nor space (passed through unchanged), and the copied end mark.
// The register channel (csr_bus) writes the five key letters and the
// direction bit; it is always ready.
// A response beat follows in the cycle after its request beat is taken; one
// beat is taken every cycle while the tables are idle and the output drains.
// Each byte costs one lookup in the registered tables. After reset, and after
// every key letter write, the table builder sweeps the 26 letters, one per
// cycle, and req_bus.ready stays low until the sweep ends. A direction write
// takes effect at once and starts no sweep. When the receiver holds
// rsp_bus.ready low, the result stays in the output register and a new
// request beat is taken only in the cycle that the waiting beat leaves.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher (
   input logic        clock,
   input logic        reset,
   kwsc_req_if.sink   req_bus,
   kwsc_rsp_if.source rsp_bus,
   kwsc_csr_if.sink   csr_bus
);
   import kwsc_pkg::*;

   key_set_type keys_ff;
   logic        direction_ff;

   logic        csr_write;
   logic        key_write;
   logic        tables_busy;

   logic        req_take;
   logic [7:0]  folded;
   logic [7:0]  offset;
   logic        is_letter;
   logic        is_space;
   letter_type  symbol_index;
   letter_type  cipher_index;
   logic [7:0]  cipher_char;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  char_out_ff;
   logic        invalid_ff;
   logic        end_flag_ff;

   // Register writes are taken every cycle; indexes past the direction bit
   // are ignored.
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;
   assign key_write     = csr_write && (csr_bus.index < CSR_DIRECTION);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < KEY_LENGTH; j++) begin
            keys_ff[j] <= LETTER_WIDTH'(j);
         end
         direction_ff <= DIR_ENCRYPT;
      end else if (csr_write) begin
         if (key_write) begin
            keys_ff[csr_bus.index - CSR_KEY_FIRST] <= csr_bus.data;
         end else if (csr_bus.index == CSR_DIRECTION) begin
            direction_ff <= csr_bus.data[0];
         end
      end
   end

   kwsc_tables u_tables (
      .clock          (clock),
      .reset          (reset),
      .rebuild        (key_write),
      .key_letters    (keys_ff),
      .lookup_index   (symbol_index),
      .lookup_decrypt (direction_ff),
      .lookup_result  (cipher_index),
      .busy           (tables_busy)
   );

   // Fold upper case to lower case, then map to an alphabet index.
   always_comb begin
      folded = req_bus.char_in;
      if (req_bus.char_in >= ASCII_UPPER_A && req_bus.char_in <= ASCII_UPPER_Z) begin
         folded = req_bus.char_in | ASCII_CASE;
      end
      is_letter    = (folded >= ASCII_LOWER_A) && (folded <= ASCII_LOWER_Z);
      is_space     = (folded == ASCII_SPACE);
      offset       = folded - ASCII_LOWER_A;
      symbol_index = is_letter ? offset[LETTER_WIDTH-1:0] : SPACE_INDEX;
      cipher_char  = (cipher_index <= LAST_LETTER) ?
                     ASCII_LOWER_A + 8'(cipher_index) : ASCII_SPACE;
   end

   // A new beat enters when the table builder is idle and the output register is empty or draining.
   assign req_bus.ready = !tables_busy && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         char_out_ff <= (is_letter || is_space) ? cipher_char : req_bus.char_in;
         invalid_ff  <= !(is_letter || is_space);
         end_flag_ff <= req_bus.end_of_message;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.char_out = char_out_ff;
   assign rsp_bus.invalid  = invalid_ff;
   assign rsp_bus.end_flag = end_flag_ff;

endmodule

[rtl/kwsc_checker.sv]
// ----------------------------------------------------------------------------
// Cipher port checker
// Watches the request and response channels for ordering and flag consistency.
// ----------------------------------------------------------------------------
module kwsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_end_of_message,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_char_out,
   input logic       rsp_invalid,
   input logic       rsp_end_flag
);
   import kwsc_pkg::*;

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat valid right after reset");

   // Every taken request beat shows up as a response beat in the cycle after it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("request beat taken but no response beat followed");

   // The end mark travels with its byte.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (rsp_end_flag == $past(req_end_of_message)))
      else $error("end flag does not match the request beat");

   // A byte flagged invalid can be neither a letter nor a space.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |->
         !((rsp_char_out >= ASCII_LOWER_A && rsp_char_out <= ASCII_LOWER_Z) ||
           (rsp_char_out >= ASCII_UPPER_A && rsp_char_out <= ASCII_UPPER_Z) ||
           rsp_char_out == ASCII_SPACE))
      else $error("letter or space flagged invalid");

   // A stalled response beat stays valid and holds its byte and invalid flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_char_out) && $stable(rsp_invalid)))
      else $error("stalled response beat changed");

endmodule

bind keyword_substitution_cipher kwsc_checker u_kwsc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_end_of_message (req_bus.end_of_message),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_char_out       (rsp_bus.char_out),
   .rsp_invalid        (rsp_bus.invalid),
   .rsp_end_flag       (rsp_bus.end_flag)
);
